// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define OPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define OPL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/opl_pkg.sv
package opl_pkg;

  localparam int ID_W        = 13;
  localparam int NODE_IDX_W  = 10;
  localparam int LEAF_ADDR_W = 12;
  localparam int WORD_W      = 16;
  localparam int COORD_W     = 31;
  localparam int MAX_NODES   = 1 << NODE_IDX_W;
  localparam int MAX_LEAVES  = 1 << LEAF_ADDR_W;

  typedef enum logic [1:0] {
    FUNC_NODE_WR = 2'd0,
    FUNC_LEAF_WR = 2'd1,
    FUNC_QUERY   = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_t;

  // Register index within the configuration map.
  typedef enum logic {
    REG_ROOT_ID    = 1'b0,
    REG_SPACE_DIMS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic shift;
  } slot_ctl_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       exhausted;
  } slot_sts_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] element_count;
    logic [ID_W-1:0]   list_start;
  } result_t;

endpackage

// File: hw/rtl/opl_slot_unit.sv
module opl_slot_unit import opl_pkg::*; #(
  parameter int COORD_BITS = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slot_ctl_t          ctl,
  input  logic [1:0]         space_dims,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic [COORD_W-1:0] z_coord,
  output slot_sts_t          sts
);

  localparam int LVL_W = $clog2(COORD_BITS + 1);

  logic [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [COORD_BITS-1:0] x_nxt, y_nxt, z_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    lvl_nxt = lvl_r;
    if (ctl.load) begin
      // drop bits above the walk depth; clear unused axes
      x_nxt   = x_coord[COORD_BITS-1:0];
      y_nxt   = (space_dims < 2'd2) ? '0 : y_coord[COORD_BITS-1:0];
      z_nxt   = (space_dims < 2'd3) ? '0 : z_coord[COORD_BITS-1:0];
      lvl_nxt = LVL_W'(COORD_BITS);
    end else if (ctl.shift) begin
      x_nxt   = {x_r[COORD_BITS-2:0], 1'b0};
      y_nxt   = {y_r[COORD_BITS-2:0], 1'b0};
      z_nxt   = {z_r[COORD_BITS-2:0], 1'b0};
      lvl_nxt = lvl_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (!rst_n) begin
      lvl_r <= '0;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  assign sts.slot      = {z_r[COORD_BITS-1], y_r[COORD_BITS-1], x_r[COORD_BITS-1]};
  assign sts.exhausted = (lvl_r == '0);

endmodule

// File: hw/rtl/opl_walker.sv
module opl_walker import opl_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int LEAF_WORDS = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [1:0]             req_func,
  input  logic [NODE_IDX_W-1:0]  req_node_index,
  input  logic [2:0]             req_child_slot,
  input  logic signed [ID_W-1:0] req_child_id,
  input  logic [LEAF_ADDR_W-1:0] req_leaf_address,
  input  logic [WORD_W-1:0]      req_leaf_word,
  input  logic signed [ID_W-1:0] root_id,
  output slot_ctl_t              slot_ctl,
  input  slot_sts_t              slot_sts,
  output logic                   res_valid,
  input  logic                   res_ready,
  output result_t                res
);

  `include "assert_macros.svh"

  localparam int NodeRows = (NODE_COUNT < MAX_NODES) ? NODE_COUNT : MAX_NODES;
  localparam int NODE_IW  = (NodeRows > 1) ? $clog2(NodeRows) : 1;
  localparam int NODE_AW  = NODE_IW + 3;
  localparam int LeafRows = (LEAF_WORDS < MAX_LEAVES) ? LEAF_WORDS : MAX_LEAVES;
  localparam int LEAF_AW  = (LeafRows > 1) ? $clog2(LeafRows) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_LEAF = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    first_r, first_nxt;
  logic [LEAF_ADDR_W-1:0]  leaf_a_r, leaf_a_nxt;
  result_t                 res_r, res_nxt;

  logic [ID_W-1:0]         node_mem [2**NODE_AW];
  logic [WORD_W-1:0]       leaf_mem [2**LEAF_AW];
  logic signed [ID_W-1:0]  node_rd_r;
  logic [WORD_W-1:0]       leaf_rd_r;

  logic                    req_acc;
  logic                    node_we, leaf_we, node_re, leaf_re;
  logic signed [ID_W-1:0]  id_cur;
  logic [LEAF_ADDR_W-1:0]  node_num, leaf_a;
  logic                    node_ok, leaf_ok;

  assign req_ready = (state_r == S_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign node_we   = req_acc && (req_func == FUNC_NODE_WR)
                     && ({22'd0, req_node_index} < 32'(NODE_COUNT));
  assign leaf_we   = req_acc && (req_func == FUNC_LEAF_WR)
                     && ({20'd0, req_leaf_address} < 32'(LEAF_WORDS));

  // Current child id: root on the first level, else the node word just read.
  assign id_cur   = first_r ? root_id : node_rd_r;
  assign node_num = id_cur[LEAF_ADDR_W-1:0] - LEAF_ADDR_W'(1);
  assign leaf_a   = ~id_cur[LEAF_ADDR_W-1:0];
  assign node_ok  = ({20'd0, node_num} < 32'(NODE_COUNT));
  assign leaf_ok  = ({20'd0, leaf_a} < 32'(LEAF_WORDS));

  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    leaf_a_nxt     = leaf_a_r;
    res_nxt        = res_r;
    node_re        = 1'b0;
    leaf_re        = 1'b0;
    slot_ctl.load  = 1'b0;
    slot_ctl.shift = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req_acc && (req_func == FUNC_QUERY)) begin
          slot_ctl.load = 1'b1;
          first_nxt     = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        res_nxt = '0;
        priority if (id_cur == '0) begin
          state_nxt = S_DONE;
        end else if (id_cur[ID_W-1]) begin
          if (leaf_ok) begin
            leaf_re    = 1'b1;
            leaf_a_nxt = leaf_a;
            state_nxt  = S_LEAF;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (slot_sts.exhausted || !node_ok) begin
          state_nxt = S_DONE;
        end else begin
          node_re        = 1'b1;
          slot_ctl.shift = 1'b1;
          first_nxt      = 1'b0;
        end
      end
      S_LEAF: begin
        res_nxt.found         = 1'b1;
        res_nxt.element_count = leaf_rd_r;
        res_nxt.list_start    = {1'b0, leaf_a_r} + ID_W'(1);
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[{req_node_index[NODE_IW-1:0], req_child_slot}] <= req_child_id;
    end
    if (node_re) begin
      node_rd_r <= node_mem[{node_num[NODE_IW-1:0], slot_sts.slot}];
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[req_leaf_address[LEAF_AW-1:0]] <= req_leaf_word;
    end
    if (leaf_re) begin
      leaf_rd_r <= leaf_mem[leaf_a[LEAF_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    leaf_a_r <= leaf_a_nxt;
    res_r    <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  `OPL_ASSERT(a_leaf_rd_in_range, leaf_re |-> leaf_ok, "leaf read beyond leaf table")
  `OPL_ASSERT(a_node_rd_levels, node_re |-> (!slot_sts.exhausted && node_ok),
    "node read after walk depth or beyond node table")
  `OPL_ASSERT_NEXT(a_leaf_to_found, state_r == S_LEAF,
    (state_r == S_DONE) && res_r.found && (res_r.list_start != '0),
    "leaf read did not yield a found result")

endmodule

// File: hw/rtl/octree_point_locate_core.sv
// Octree point locator.
// Input channel (in_*): one request per valid/ready handshake. func selects a
// node-table child write, a leaf-table word write or a point query. Writes
// finish in the accept cycle and return nothing; a query returns exactly one
// result on the out_* channel (found, element_count, list_start).
// Configuration (APB, pready always high): root_id at 0x0, space_dims at 0x4.
// Write these only while no query is in flight.
// A query's walk ends at an empty child, a node past the table or the last
// level, or at a leaf in the table, where a leaf-table read follows. Each
// level is one dependent node-table read, with the slot picked by the
// coordinate shifter.
// One query in flight at a time; in_ready is low while it walks and stays
// low until the output register takes its result. A write leaves in_ready
// high.
// The output register holds the result until out_ready; the walker
// may finish the next query meanwhile and then holds it until the register
// frees. Reset: root_id clears to 0 (empty tree), space_dims to 3, the
// output register empties. The tables are not cleared; read them only
// after writing.
module octree_point_locate_core import opl_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int LEAF_WORDS = 4096,
  parameter int COORD_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [NODE_IDX_W-1:0]  in_node_index,
  input  logic [2:0]             in_child_slot,
  input  logic signed [ID_W-1:0] in_child_id,
  input  logic [LEAF_ADDR_W-1:0] in_leaf_address,
  input  logic [WORD_W-1:0]      in_leaf_word,
  input  logic [COORD_W-1:0]     in_x_coord,
  input  logic [COORD_W-1:0]     in_y_coord,
  input  logic [COORD_W-1:0]     in_z_coord,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [WORD_W-1:0]      out_element_count,
  output logic [ID_W-1:0]        out_list_start,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic signed [ID_W-1:0] root_r, root_nxt;
  logic [1:0]             dims_r, dims_nxt;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  slot_ctl_t              slot_ctl;
  slot_sts_t              slot_sts;
  logic                   res_valid, res_ready;
  result_t                res;

  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r, out_nxt;

  // Configuration registers: write on the access phase, decode by word index.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    root_nxt = root_r;
    dims_nxt = dims_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROOT_ID:    root_nxt = pwdata[ID_W-1:0];
        REG_SPACE_DIMS: dims_nxt = pwdata[1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROOT_ID:    prdata = {{(32-ID_W){root_r[ID_W-1]}}, root_r};
      REG_SPACE_DIMS: prdata = {30'd0, dims_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      dims_r <= 2'd3;
    end else begin
      root_r <= root_nxt;
      dims_r <= dims_nxt;
    end
  end

  // Coordinate shifter: feeds one slot per level to the walker.
  opl_slot_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_slot (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (slot_ctl),
    .space_dims (dims_r),
    .x_coord    (in_x_coord),
    .y_coord    (in_y_coord),
    .z_coord    (in_z_coord),
    .sts        (slot_sts)
  );

  // Sequencer with the node and leaf tables.
  opl_walker #(
    .NODE_COUNT (NODE_COUNT),
    .LEAF_WORDS (LEAF_WORDS)
  ) u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (in_valid),
    .req_ready        (in_ready),
    .req_func         (in_func),
    .req_node_index   (in_node_index),
    .req_child_slot   (in_child_slot),
    .req_child_id     (in_child_id),
    .req_leaf_address (in_leaf_address),
    .req_leaf_word    (in_leaf_word),
    .root_id          (root_r),
    .slot_ctl         (slot_ctl),
    .slot_sts         (slot_sts),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  // Output register: take a new result when empty or draining this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_r.found;
  assign out_element_count = out_r.element_count;
  assign out_list_start    = out_r.list_start;

endmodule

// File: tb/sv/octree_point_locate_chk.sv
// Watches the request, result and configuration ports of the point locator,
// predicts every query answer and compares it with what comes out.
module octree_point_locate_chk import opl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [NODE_IDX_W-1:0]  in_node_index,
  input  logic [2:0]             in_child_slot,
  input  logic signed [ID_W-1:0] in_child_id,
  input  logic [LEAF_ADDR_W-1:0] in_leaf_address,
  input  logic [WORD_W-1:0]      in_leaf_word,
  input  logic [COORD_W-1:0]     in_x_coord,
  input  logic [COORD_W-1:0]     in_y_coord,
  input  logic [COORD_W-1:0]     in_z_coord,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_found,
  input  logic [WORD_W-1:0]      out_element_count,
  input  logic [ID_W-1:0]        out_list_start,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     mismatches,
  output int                     queries_open
);

  logic signed [ID_W-1:0] child_ids [MAX_NODES*8];
  logic [WORD_W-1:0]      leaf_words [MAX_LEAVES];
  logic signed [ID_W-1:0] root_id;
  logic [1:0]             space_dims;
  result_t                open_answers [$];

  initial begin
    mismatches   = 0;
    queries_open = 0;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want, got);
    mismatches++;
  endtask

  // Walk from the root, one coordinate bit per level, most significant first.
  function automatic result_t locate_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                           logic [COORD_W-1:0] z);
    result_t    r;
    int         id;
    int         lvl;
    int         leaf;
    logic [2:0] slot;
    r = '0;
    if (space_dims < 2) y = '0;
    if (space_dims < 3) z = '0;
    id  = root_id;
    lvl = COORD_W - 1;
    while (id > 0 && lvl >= 0) begin
      if (id > MAX_NODES) begin
        id = 0;
      end else begin
        slot = {z[lvl], y[lvl], x[lvl]};
        id   = child_ids[(id - 1) * 8 + slot];
        lvl--;
      end
    end
    if (id < 0) begin
      leaf = -(id + 1);
      if (leaf < MAX_LEAVES) begin
        r.found         = 1'b1;
        r.element_count = leaf_words[leaf];
        r.list_start    = ID_W'(leaf + 1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      root_id    = '0;
      space_dims = 2'd3;
      open_answers.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_ROOT_ID:    root_id = pwdata[ID_W-1:0];
          REG_SPACE_DIMS: space_dims = pwdata[1:0];
        endcase
      end
      if (out_valid && out_ready) begin
        if (open_answers.size() == 0) begin
          report_mismatch("result count", 0, 1);
        end else begin
          want = open_answers.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", want.found, out_found);
          if (out_element_count !== want.element_count)
            report_mismatch("element_count", want.element_count, out_element_count);
          if (out_list_start !== want.list_start)
            report_mismatch("list_start", want.list_start, out_list_start);
        end
      end
      if (in_valid && in_ready) begin
        case (func_t'(in_func))
          FUNC_NODE_WR: child_ids[{in_node_index, in_child_slot}] = in_child_id;
          FUNC_LEAF_WR: leaf_words[in_leaf_address] = in_leaf_word;
          FUNC_QUERY:   open_answers.push_back(locate_point(in_x_coord, in_y_coord,
                                                            in_z_coord));
          default: ;
        endcase
      end
    end
    queries_open = open_answers.size();
  end

endmodule

// File: tb/sv/octree_point_locate_core_tb.sv
module octree_point_locate_core_tb import opl_pkg::*;;

  // Counted requests per random phase; six phases with changing settings.
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_CYCLES     = 400;
  // Longest walk plus pipeline slack: wait this long once nothing is open.
  localparam int SETTLE_CYCLES   = COORD_W + 8;

  typedef struct packed {
    logic [1:0]             func;
    logic [NODE_IDX_W-1:0]  node;
    logic [2:0]             slot;
    logic [ID_W-1:0]        child;
    logic [LEAF_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]      word;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     z;
  } request_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_func;
  logic [NODE_IDX_W-1:0]  in_node_index;
  logic [2:0]             in_child_slot;
  logic signed [ID_W-1:0] in_child_id;
  logic [LEAF_ADDR_W-1:0] in_leaf_address;
  logic [WORD_W-1:0]      in_leaf_word;
  logic [COORD_W-1:0]     in_x_coord;
  logic [COORD_W-1:0]     in_y_coord;
  logic [COORD_W-1:0]     in_z_coord;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_found;
  logic [WORD_W-1:0]      out_element_count;
  logic [ID_W-1:0]        out_list_start;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int mismatches;
  int queries_open;

  // Idle percentages of the two sides, changed per phase by the stimulus.
  int snd_idle_pct = 28;
  int rcv_idle_pct = 47;
  bit start_hold   = 1'b0;

  // Shadow of what has been written. A node counts as ready once all eight
  // slots hold an id; a leaf once its count word is written. Children and
  // roots are only ever taken from ready entries, so no walk reads a table
  // entry that was never written.
  bit slot_written [MAX_NODES*8];
  bit node_ready   [MAX_NODES];
  bit leaf_ready   [MAX_LEAVES];
  int ready_nodes  [$];
  int ready_leaves [$];

  octree_point_locate_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_node_index     (in_node_index),
    .in_child_slot     (in_child_slot),
    .in_child_id       (in_child_id),
    .in_leaf_address   (in_leaf_address),
    .in_leaf_word      (in_leaf_word),
    .in_x_coord        (in_x_coord),
    .in_y_coord        (in_y_coord),
    .in_z_coord        (in_z_coord),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_element_count (out_element_count),
    .out_list_start    (out_list_start),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  octree_point_locate_chk i_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_node_index     (in_node_index),
    .in_child_slot     (in_child_slot),
    .in_child_id       (in_child_id),
    .in_leaf_address   (in_leaf_address),
    .in_leaf_word      (in_leaf_word),
    .in_x_coord        (in_x_coord),
    .in_y_coord        (in_y_coord),
    .in_z_coord        (in_z_coord),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_element_count (out_element_count),
    .out_list_start    (out_list_start),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatches        (mismatches),
    .queries_open      (queries_open)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: drop ready at random, and once hold off for a long stretch
  // so the walker and the output register fill and the input stalls.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_hold && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Fill every field with noise; callers override the ones that matter.
  function automatic request_t random_request(func_t f);
    request_t r;
    r.func  = f;
    r.node  = NODE_IDX_W'($urandom);
    r.slot  = 3'($urandom);
    r.child = ID_W'($urandom);
    r.addr  = LEAF_ADDR_W'($urandom);
    r.word  = WORD_W'($urandom);
    r.x     = COORD_W'($urandom);
    r.y     = COORD_W'($urandom);
    r.z     = COORD_W'($urandom);
    return r;
  endfunction

  // Pick a child id that only leads to ready entries: empty, a ready leaf,
  // a ready node, or a node number past the end of the table.
  function automatic logic [ID_W-1:0] pick_child_id();
    int n;
    n = $urandom_range(99);
    if (n < 15) return '0;
    if (n < 20) return ID_W'($urandom_range(4095, MAX_NODES + 1));
    if (n < 60) return ID_W'(-(ready_leaves[$urandom_range(ready_leaves.size() - 1)] + 1));
    return ID_W'(ready_nodes[$urandom_range(ready_nodes.size() - 1)] + 1);
  endfunction

  // Mostly full-width coordinates; some tiny ones to keep walks on slot 0.
  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(9) < 7) return COORD_W'($urandom);
    return COORD_W'($urandom_range(15));
  endfunction

  // Enter and leave at a falling edge. Hold valid and payload until the
  // request is taken; leave valid high so a back-to-back request needs no
  // second assignment in the same step.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= r.func;
    in_node_index   <= r.node;
    in_child_slot   <= r.slot;
    in_child_id     <= r.child;
    in_leaf_address <= r.addr;
    in_leaf_word    <= r.word;
    in_x_coord      <= r.x;
    in_y_coord      <= r.y;
    in_z_coord      <= r.z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_node(int idx, int slot, logic [ID_W-1:0] id);
    request_t r;
    int       s;
    bit       all_set;
    r       = random_request(FUNC_NODE_WR);
    r.node  = NODE_IDX_W'(idx);
    r.slot  = 3'(slot);
    r.child = id;
    send_request(r);
    slot_written[idx * 8 + slot] = 1'b1;
    all_set = 1'b1;
    for (s = 0; s < 8; s++)
      if (!slot_written[idx * 8 + s]) all_set = 1'b0;
    if (all_set && !node_ready[idx]) begin
      node_ready[idx] = 1'b1;
      ready_nodes.push_back(idx);
    end
  endtask

  task automatic write_leaf(int addr, logic [WORD_W-1:0] word);
    request_t r;
    r      = random_request(FUNC_LEAF_WR);
    r.addr = LEAF_ADDR_W'(addr);
    r.word = word;
    send_request(r);
    if (!leaf_ready[addr]) begin
      leaf_ready[addr] = 1'b1;
      ready_leaves.push_back(addr);
    end
  endtask

  task automatic ask_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    request_t r;
    r   = random_request(FUNC_QUERY);
    r.x = x;
    r.y = y;
    r.z = z;
    send_request(r);
  endtask

  // Two-phase register write: setup, then access until pready. Idle
  // afterwards so a following write starts in a later step.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending, wait for every open query to answer, then let the
  // walker go quiet before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (queries_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  localparam logic [COORD_W-1:0] TOP_BIT  = COORD_W'(1) << (COORD_W - 1);
  localparam logic [COORD_W-1:0] ALL_ONES = '1;

  initial begin
    int                    p;
    int                    n;
    int                    s;
    int                    idx;
    int                    pick;
    logic [ID_W-1:0]       root;
    logic [1:0]            dims_seq [PHASES];
    request_t              r;
    dims_seq = '{2'd3, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_QUERY;
    in_node_index   = '0;
    in_child_slot   = '0;
    in_child_id     = '0;
    in_leaf_address = '0;
    in_leaf_word    = '0;
    in_x_coord      = '0;
    in_y_coord      = '0;
    in_z_coord      = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Empty tree right after reset.
    ask_point('0, '0, '0);
    // Leaves at both ends of the leaf table.
    write_leaf(MAX_LEAVES - 1, '1);
    write_leaf(0, '0);
    // Last node: slots 0 and 4 loop back to itself, others hit every kind
    // of child (empty, node past the table, both leaves).
    write_node(MAX_NODES - 1, 0, ID_W'(MAX_NODES));
    write_node(MAX_NODES - 1, 1, '0);
    write_node(MAX_NODES - 1, 2, ID_W'(4095));
    write_node(MAX_NODES - 1, 3, ID_W'(-1));
    write_node(MAX_NODES - 1, 4, ID_W'(MAX_NODES));
    write_node(MAX_NODES - 1, 5, ID_W'(-1));
    write_node(MAX_NODES - 1, 6, '0);
    write_node(MAX_NODES - 1, 7, ID_W'(-MAX_LEAVES));
    // Reserved function code: no effect, no answer.
    r = random_request(FUNC_RSVD);
    send_request(r);
    settle();
    write_reg(REG_ROOT_ID, 32'(MAX_NODES));
    write_reg(REG_SPACE_DIMS, 32'd3);
    ask_point('0, '0, '0);                        // loops on slot 0 until levels run out
    ask_point(COORD_W'(1), COORD_W'(1), COORD_W'(1)); // leaf at the deepest level
    ask_point(ALL_ONES, ALL_ONES, ALL_ONES);      // leaf right below the root
    ask_point(TOP_BIT, '0, '0);                   // empty child
    ask_point('0, TOP_BIT, '0);                   // node past the table
    ask_point(TOP_BIT, TOP_BIT, '0);              // leaf zero, empty count
    // Reduced dimensions mask y and z; zero behaves like one.
    settle();
    write_reg(REG_SPACE_DIMS, 32'd1);
    ask_point(ALL_ONES, ALL_ONES, ALL_ONES);
    settle();
    write_reg(REG_SPACE_DIMS, 32'd2);
    ask_point(ALL_ONES, ALL_ONES, ALL_ONES);
    settle();
    write_reg(REG_SPACE_DIMS, 32'd0);
    ask_point(ALL_ONES, ALL_ONES, ALL_ONES);
    // Root that is itself a leaf.
    settle();
    write_reg(REG_ROOT_ID, 32'(-MAX_LEAVES));
    write_reg(REG_SPACE_DIMS, 32'd3);
    ask_point(rand_coord(), rand_coord(), rand_coord());

    // Random part: grow the tree and query it under changing settings.
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p / 2)
        0: begin snd_idle_pct = 28; rcv_idle_pct = 47; end
        1: begin snd_idle_pct = 47; rcv_idle_pct = 28; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      if (p == 1) start_hold = 1'b1;
      if (p == 0) root = ID_W'(MAX_NODES);
      else if (p == PHASES - 1) root = ID_W'(-MAX_LEAVES);
      else if ($urandom_range(4) == 0)
        root = ID_W'(-(ready_leaves[$urandom_range(ready_leaves.size() - 1)] + 1));
      else
        root = ID_W'(ready_nodes[$urandom_range(ready_nodes.size() - 1)] + 1);
      write_reg(REG_ROOT_ID, 32'(signed'(root)));
      write_reg(REG_SPACE_DIMS, 32'(dims_seq[p]));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if ($urandom_range(9) < 7) idx = $urandom_range(31);
        else idx = $urandom_range(MAX_NODES - 1);
        if (pick < 12) begin
          if ($urandom_range(9) < 6) write_leaf($urandom_range(63), WORD_W'($urandom));
          else write_leaf($urandom_range(MAX_LEAVES - 1), WORD_W'($urandom));
          n++;
        end else if (pick < 40) begin
          // A whole node in one burst makes it usable right away.
          if ($urandom_range(3) == 0) begin
            for (s = 0; s < 8; s++) write_node(idx, s, pick_child_id());
            n += 8;
          end else begin
            write_node(idx, $urandom_range(7), pick_child_id());
            n++;
          end
        end else if (pick < 95) begin
          ask_point(rand_coord(), rand_coord(), rand_coord());
          n++;
        end else begin
          r = random_request(FUNC_RSVD);
          send_request(r);
        end
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    while (queries_open != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
